@@ rtl/bs_vlc_run_level_decoder_top_assert.svh @@
// assertion macros for the run/level decoder
`ifndef BS_VLC_RUN_LEVEL_DECODER_TOP_ASSERT_SVH
`define BS_VLC_RUN_LEVEL_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define BSVLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bsvlc assertion failed");

// next-cycle implication
`define BSVLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bsvlc assertion failed");

`endif

@@ rtl/bsvlc_pkg.sv @@
// shared types, constants and vlc table for the run/level decoder
package bsvlc_pkg;

	localparam logic [1:0] STAT_CODE = 2'd0;
	localparam logic [1:0] STAT_DONE = 2'd1;
	localparam logic [1:0] STAT_ERR  = 2'd2;

	localparam logic CFG_MB_COLUMNS = 1'b0;
	localparam logic CFG_MB_ROWS    = 1'b1;

	localparam logic [15:0] EOB_WORD = 16'hFE00;
	localparam int MAX_RESULTS = 16;
	localparam int RES_CNT_W = $clog2(MAX_RESULTS);
	localparam int VLC_N = 111;

	typedef struct packed {
		logic [15:0] data_word;
		logic        frame_start;
		logic        frame_end;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code_word;
		logic [1:0]  status;
		logic        last_of_input;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LAST
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic commit;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic pend_valid;
		logic out_free;
		logic emit;
		logic terminal;
		logic hdr_error;
		logic hdr_decode;
	} dp_status_t;

	typedef struct packed {
		logic [4:0]  len;
		logic [15:0] code;
		logic [4:0]  run;
		logic [5:0]  lev;
	} vlc_ent_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] len;
		logic [4:0] run;
		logic [5:0] lev;
	} vlc_hit_t;

	localparam vlc_ent_t VLC_TABLE [VLC_N] = '{
		'{5'd2, 16'b11, 5'd0, 6'd1}, '{5'd3, 16'b011, 5'd1, 6'd1},
		'{5'd4, 16'b0100, 5'd0, 6'd2}, '{5'd4, 16'b0101, 5'd2, 6'd1},
		'{5'd5, 16'b00101, 5'd0, 6'd3}, '{5'd5, 16'b00111, 5'd3, 6'd1},
		'{5'd5, 16'b00110, 5'd4, 6'd1},
		'{5'd6, 16'b000110, 5'd1, 6'd2}, '{5'd6, 16'b000111, 5'd5, 6'd1},
		'{5'd6, 16'b000101, 5'd6, 6'd1}, '{5'd6, 16'b000100, 5'd7, 6'd1},
		'{5'd7, 16'b0000110, 5'd0, 6'd4}, '{5'd7, 16'b0000100, 5'd2, 6'd2},
		'{5'd7, 16'b0000111, 5'd8, 6'd1}, '{5'd7, 16'b0000101, 5'd9, 6'd1},
		'{5'd8, 16'b00100110, 5'd0, 6'd5}, '{5'd8, 16'b00100001, 5'd0, 6'd6},
		'{5'd8, 16'b00100101, 5'd1, 6'd3}, '{5'd8, 16'b00100100, 5'd3, 6'd2},
		'{5'd8, 16'b00100111, 5'd10, 6'd1}, '{5'd8, 16'b00100011, 5'd11, 6'd1},
		'{5'd8, 16'b00100010, 5'd12, 6'd1}, '{5'd8, 16'b00100000, 5'd13, 6'd1},
		'{5'd10, 16'b0000001010, 5'd0, 6'd7}, '{5'd10, 16'b0000001100, 5'd1, 6'd4},
		'{5'd10, 16'b0000001011, 5'd2, 6'd3}, '{5'd10, 16'b0000001111, 5'd4, 6'd2},
		'{5'd10, 16'b0000001001, 5'd5, 6'd2}, '{5'd10, 16'b0000001110, 5'd14, 6'd1},
		'{5'd10, 16'b0000001101, 5'd15, 6'd1}, '{5'd10, 16'b0000001000, 5'd16, 6'd1},
		'{5'd12, 16'b000000011101, 5'd0, 6'd8}, '{5'd12, 16'b000000011000, 5'd0, 6'd9},
		'{5'd12, 16'b000000010011, 5'd0, 6'd10}, '{5'd12, 16'b000000010000, 5'd0, 6'd11},
		'{5'd12, 16'b000000011011, 5'd1, 6'd5}, '{5'd12, 16'b000000010100, 5'd2, 6'd4},
		'{5'd12, 16'b000000011100, 5'd3, 6'd3}, '{5'd12, 16'b000000010010, 5'd4, 6'd3},
		'{5'd12, 16'b000000011110, 5'd6, 6'd2}, '{5'd12, 16'b000000010101, 5'd7, 6'd2},
		'{5'd12, 16'b000000010001, 5'd8, 6'd2}, '{5'd12, 16'b000000011111, 5'd17, 6'd1},
		'{5'd12, 16'b000000011010, 5'd18, 6'd1}, '{5'd12, 16'b000000011001, 5'd19, 6'd1},
		'{5'd12, 16'b000000010111, 5'd20, 6'd1}, '{5'd12, 16'b000000010110, 5'd21, 6'd1},
		'{5'd13, 16'b0000000011010, 5'd0, 6'd12}, '{5'd13, 16'b0000000011001, 5'd0, 6'd13},
		'{5'd13, 16'b0000000011000, 5'd0, 6'd14}, '{5'd13, 16'b0000000010111, 5'd0, 6'd15},
		'{5'd13, 16'b0000000010110, 5'd1, 6'd6}, '{5'd13, 16'b0000000010101, 5'd1, 6'd7},
		'{5'd13, 16'b0000000010100, 5'd2, 6'd5}, '{5'd13, 16'b0000000010011, 5'd3, 6'd4},
		'{5'd13, 16'b0000000010010, 5'd5, 6'd3}, '{5'd13, 16'b0000000010001, 5'd9, 6'd2},
		'{5'd13, 16'b0000000010000, 5'd10, 6'd2}, '{5'd13, 16'b0000000011111, 5'd22, 6'd1},
		'{5'd13, 16'b0000000011110, 5'd23, 6'd1}, '{5'd13, 16'b0000000011101, 5'd24, 6'd1},
		'{5'd13, 16'b0000000011100, 5'd25, 6'd1}, '{5'd13, 16'b0000000011011, 5'd26, 6'd1},
		'{5'd14, 16'b00000000011111, 5'd0, 6'd16}, '{5'd14, 16'b00000000011110, 5'd0, 6'd17},
		'{5'd14, 16'b00000000011101, 5'd0, 6'd18}, '{5'd14, 16'b00000000011100, 5'd0, 6'd19},
		'{5'd14, 16'b00000000011011, 5'd0, 6'd20}, '{5'd14, 16'b00000000011010, 5'd0, 6'd21},
		'{5'd14, 16'b00000000011001, 5'd0, 6'd22}, '{5'd14, 16'b00000000011000, 5'd0, 6'd23},
		'{5'd14, 16'b00000000010111, 5'd0, 6'd24}, '{5'd14, 16'b00000000010110, 5'd0, 6'd25},
		'{5'd14, 16'b00000000010101, 5'd0, 6'd26}, '{5'd14, 16'b00000000010100, 5'd0, 6'd27},
		'{5'd14, 16'b00000000010011, 5'd0, 6'd28}, '{5'd14, 16'b00000000010010, 5'd0, 6'd29},
		'{5'd14, 16'b00000000010001, 5'd0, 6'd30}, '{5'd14, 16'b00000000010000, 5'd0, 6'd31},
		'{5'd15, 16'b000000000011000, 5'd0, 6'd32}, '{5'd15, 16'b000000000010111, 5'd0, 6'd33},
		'{5'd15, 16'b000000000010110, 5'd0, 6'd34}, '{5'd15, 16'b000000000010101, 5'd0, 6'd35},
		'{5'd15, 16'b000000000010100, 5'd0, 6'd36}, '{5'd15, 16'b000000000010011, 5'd0, 6'd37},
		'{5'd15, 16'b000000000010010, 5'd0, 6'd38}, '{5'd15, 16'b000000000010001, 5'd0, 6'd39},
		'{5'd15, 16'b000000000010000, 5'd0, 6'd40}, '{5'd15, 16'b000000000011111, 5'd1, 6'd8},
		'{5'd15, 16'b000000000011110, 5'd1, 6'd9}, '{5'd15, 16'b000000000011101, 5'd1, 6'd10},
		'{5'd15, 16'b000000000011100, 5'd1, 6'd11}, '{5'd15, 16'b000000000011011, 5'd1, 6'd12},
		'{5'd15, 16'b000000000011010, 5'd1, 6'd13}, '{5'd15, 16'b000000000011001, 5'd1, 6'd14},
		'{5'd16, 16'b0000000000010011, 5'd1, 6'd15}, '{5'd16, 16'b0000000000010010, 5'd1, 6'd16},
		'{5'd16, 16'b0000000000010001, 5'd1, 6'd17}, '{5'd16, 16'b0000000000010000, 5'd1, 6'd18},
		'{5'd16, 16'b0000000000010100, 5'd6, 6'd3}, '{5'd16, 16'b0000000000011010, 5'd11, 6'd2},
		'{5'd16, 16'b0000000000011001, 5'd12, 6'd2}, '{5'd16, 16'b0000000000011000, 5'd13, 6'd2},
		'{5'd16, 16'b0000000000010111, 5'd14, 6'd2}, '{5'd16, 16'b0000000000010110, 5'd15, 6'd2},
		'{5'd16, 16'b0000000000010101, 5'd16, 6'd2}, '{5'd16, 16'b0000000000011111, 5'd27, 6'd1},
		'{5'd16, 16'b0000000000011110, 5'd28, 6'd1}, '{5'd16, 16'b0000000000011101, 5'd29, 6'd1},
		'{5'd16, 16'b0000000000011100, 5'd30, 6'd1}, '{5'd16, 16'b0000000000011011, 5'd31, 6'd1}
	};

	// codes are prefix free, so at most one entry matches
	function automatic vlc_hit_t vlc_lookup(input logic [15:0] win);
		vlc_hit_t r;
		r = '0;
		for (int i = 0; i < VLC_N; i++) begin
			if ((win >> (5'd16 - VLC_TABLE[i].len)) == VLC_TABLE[i].code) begin
				r.hit = 1'b1;
				r.len = VLC_TABLE[i].len;
				r.run = VLC_TABLE[i].run;
				r.lev = VLC_TABLE[i].lev;
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/bsvlc_ctrl.sv @@
// controller state machine of the run/level decoder
module bsvlc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  bsvlc_pkg::dp_status_t  stat,
	output bsvlc_pkg::dp_cmd_t     cmd,
	output logic                   in_stall
);

	bsvlc_pkg::ctrl_state_t state_q, state_d;
	logic [bsvlc_pkg::RES_CNT_W-1:0] res_cnt_q;
	logic can_commit;
	logic cap_hit;

	assign can_commit = stat.emit && (!stat.pend_valid || stat.out_free);
	assign cap_hit = (res_cnt_q == bsvlc_pkg::RES_CNT_W'(bsvlc_pkg::MAX_RESULTS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsvlc_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (stat.hdr_error) state_d = bsvlc_pkg::ST_LAST;
					else if (stat.hdr_decode) state_d = bsvlc_pkg::ST_DECODE;
				end
			end
			bsvlc_pkg::ST_DECODE: begin
				if (stat.emit) begin
					if (can_commit && (stat.terminal || cap_hit)) state_d = bsvlc_pkg::ST_LAST;
				end else begin
					state_d = stat.pend_valid ? bsvlc_pkg::ST_LAST : bsvlc_pkg::ST_IDLE;
				end
			end
			bsvlc_pkg::ST_LAST: begin
				if (stat.out_free) state_d = bsvlc_pkg::ST_IDLE;
			end
			default: state_d = bsvlc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			bsvlc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.accept = in_valid;
			end
			bsvlc_pkg::ST_DECODE: cmd.commit = can_commit;
			bsvlc_pkg::ST_LAST: cmd.finish = stat.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsvlc_pkg::ST_IDLE;
			res_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) res_cnt_q <= '0;
			else if (cmd.commit) res_cnt_q <= res_cnt_q + 1'b1;
		end
	end

endmodule

@@ rtl/bsvlc_datapath.sv @@
// bit buffer, frame state, code decode and result registers
module bsvlc_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bsvlc_pkg::in_item_t    in_item,
	input  logic                   cfg_valid,
	input  logic                   cfg_index,
	input  logic [6:0]             cfg_data,
	input  logic                   out_stall,
	input  bsvlc_pkg::dp_cmd_t     cmd,
	output bsvlc_pkg::dp_status_t  stat,
	output logic                   out_valid,
	output bsvlc_pkg::out_item_t   out_item
);

	logic [6:0]  cols_q;
	logic [5:0]  rows_q;
	logic [47:0] buf_q;
	logic [5:0]  cnt_q;
	logic [2:0]  hdr_q;
	logic [5:0]  qs_q;
	logic [15:0] bc_q;
	logic        dc_q, done_q, flush_q;
	logic [15:0] pend_code_q;
	logic [1:0]  pend_stat_q;
	logic        pend_valid_q;
	logic        out_valid_q;
	bsvlc_pkg::out_item_t out_q;

	logic [12:0] prod;
	logic [15:0] nblocks;
	logic        out_free;

	// decode step
	bsvlc_pkg::vlc_hit_t lk;
	logic        emit, term, clr_dc, set_dc, inc_bc;
	logic [4:0]  drop;
	logic [15:0] code;
	logic [1:0]  code_stat;
	logic        eob, esc, sign;
	logic [9:0]  lev10;
	logic [5:0]  sign_idx;

	// header / append on accept
	logic        e_done, e_flush, e_dc;
	logic [2:0]  e_hdr;
	logic [5:0]  e_qs, e_cnt;
	logic [47:0] e_buf;
	logic [15:0] e_bc;
	logic        n_done, n_flush, hdr_err, hdr_dec;
	logic [2:0]  n_hdr;
	logic [5:0]  n_qs, n_cnt;
	logic [47:0] n_buf;

	assign prod = 13'(cols_q) * 13'(rows_q);
	assign nblocks = 16'({prod, 2'b00}) + 16'({prod, 1'b0});
	assign out_free = !out_valid_q || !out_stall;

	assign lk = bsvlc_pkg::vlc_lookup(buf_q[47:32]);
	assign sign_idx = 6'd47 - {1'b0, lk.len};
	assign sign = buf_q[sign_idx];
	assign lev10 = sign ? (10'd0 - {4'b0, lk.lev}) : {4'b0, lk.lev};
	assign eob = ((cnt_q >= 6'd2) || flush_q) && (buf_q[47:46] == 2'b10);
	assign esc = (buf_q[47:42] == 6'b000001);

	always_comb begin
		emit = 1'b0;
		term = 1'b0;
		clr_dc = 1'b0;
		set_dc = 1'b0;
		inc_bc = 1'b0;
		drop = 5'd0;
		code = 16'd0;
		code_stat = bsvlc_pkg::STAT_CODE;
		if (bc_q >= nblocks) begin
			emit = 1'b1;
			term = 1'b1;
			code_stat = bsvlc_pkg::STAT_DONE;
		end else if (dc_q) begin
			if (flush_q && cnt_q == 6'd0) begin
				emit = 1'b1;
				term = 1'b1;
				code_stat = bsvlc_pkg::STAT_DONE;
			end else if (flush_q || cnt_q >= 6'd10) begin
				emit = 1'b1;
				clr_dc = 1'b1;
				drop = 5'd10;
				code = {qs_q, buf_q[47:38]};
			end
		end else if (!eob && !flush_q && (cnt_q < 6'd17 || (esc && cnt_q < 6'd22))) begin
			emit = 1'b0;
		end else if (eob) begin
			emit = 1'b1;
			set_dc = 1'b1;
			inc_bc = 1'b1;
			drop = 5'd2;
			code = bsvlc_pkg::EOB_WORD;
		end else if (esc) begin
			emit = 1'b1;
			drop = 5'd22;
			code = buf_q[41:26];
		end else if (!lk.hit) begin
			emit = 1'b1;
			term = 1'b1;
			code_stat = bsvlc_pkg::STAT_ERR;
		end else begin
			emit = 1'b1;
			drop = lk.len + 5'd1;
			code = {1'b0, lk.run, lev10};
		end
	end

	// frame_start restarts the frame before the word is used
	always_comb begin
		e_done  = in_item.frame_start ? 1'b0 : done_q;
		e_flush = in_item.frame_start ? 1'b0 : flush_q;
		e_dc    = in_item.frame_start ? 1'b1 : dc_q;
		e_hdr   = in_item.frame_start ? 3'd0 : hdr_q;
		e_qs    = in_item.frame_start ? 6'd1 : qs_q;
		e_cnt   = in_item.frame_start ? 6'd0 : cnt_q;
		e_buf   = in_item.frame_start ? 48'd0 : buf_q;
		e_bc    = in_item.frame_start ? 16'd0 : bc_q;
		n_done  = e_done;
		n_flush = e_flush;
		n_hdr   = e_hdr;
		n_qs    = e_qs;
		n_cnt   = e_cnt;
		n_buf   = e_buf;
		hdr_err = 1'b0;
		hdr_dec = 1'b0;
		if (!e_done) begin
			hdr_dec = 1'b1;
			if (!e_flush) begin
				if (e_hdr < 3'd4) begin
					if (e_hdr == 3'd2) begin
						n_qs = (in_item.data_word[5:0] == 6'd0) ? 6'd1 : in_item.data_word[5:0];
					end
					n_hdr = e_hdr + 3'd1;
					if (n_hdr < 3'd4) begin
						hdr_dec = 1'b0;
						if (in_item.frame_end) begin
							hdr_err = 1'b1;
							n_done = 1'b1;
						end
					end
				end else if (e_cnt <= 6'd32) begin
					n_buf = e_buf | ({in_item.data_word, 32'd0} >> e_cnt);
					n_cnt = e_cnt + 6'd16;
				end
				if (hdr_dec && in_item.frame_end) n_flush = 1'b1;
			end
		end
	end

	assign stat.pend_valid = pend_valid_q;
	assign stat.out_free = out_free;
	assign stat.emit = emit;
	assign stat.terminal = term;
	assign stat.hdr_error = hdr_err;
	assign stat.hdr_decode = hdr_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 7'd20;
			rows_q <= 6'd15;
			buf_q <= '0;
			cnt_q <= '0;
			hdr_q <= '0;
			qs_q <= 6'd1;
			bc_q <= '0;
			dc_q <= 1'b1;
			done_q <= 1'b0;
			flush_q <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == bsvlc_pkg::CFG_MB_COLUMNS) cols_q <= cfg_data;
				else rows_q <= cfg_data[5:0];
			end
			if (cmd.accept) begin
				buf_q <= n_buf;
				cnt_q <= n_cnt;
				hdr_q <= n_hdr;
				qs_q <= n_qs;
				bc_q <= e_bc;
				dc_q <= e_dc;
				done_q <= n_done;
				flush_q <= n_flush;
				if (hdr_err) pend_valid_q <= 1'b1;
			end else if (cmd.commit) begin
				buf_q <= buf_q << drop;
				cnt_q <= (cnt_q > 6'(drop)) ? cnt_q - 6'(drop) : 6'd0;
				if (term) done_q <= 1'b1;
				if (clr_dc) dc_q <= 1'b0;
				if (set_dc) dc_q <= 1'b1;
				if (inc_bc) bc_q <= bc_q + 16'd1;
				pend_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				pend_valid_q <= 1'b0;
			end
			if ((cmd.commit && pend_valid_q) || cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept && hdr_err) begin
			pend_code_q <= 16'd0;
			pend_stat_q <= bsvlc_pkg::STAT_ERR;
		end else if (cmd.commit) begin
			pend_code_q <= code;
			pend_stat_q <= code_stat;
		end
		if ((cmd.commit && pend_valid_q) || cmd.finish) begin
			out_q.code_word <= pend_code_q;
			out_q.status <= pend_stat_q;
			out_q.last_of_input <= cmd.finish;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

endmodule

@@ rtl/bs_vlc_run_level_decoder_top.sv @@
// top level of the run/level vlc decoder
// one code per cycle while the output does not stall; a word with n results holds the input
// through its take, n decodes, one decode short of bits and the hand-off, or skips the
// decode short of bits when it ends the frame; header and ignored words are only taken,
// a word with no result also tries a decode short of bits; output stalls lengthen these
// reset (arst_n low) clears the frame state, sets mb_columns 20 and mb_rows 15
`include "bs_vlc_run_level_decoder_top_assert.svh"

module bs_vlc_run_level_decoder_top (
	input  logic                 clk,
	input  logic                 arst_n,
	// input word channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bsvlc_pkg::in_item_t  in_item,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output bsvlc_pkg::out_item_t out_item,
	// register write channel: index 0 mb_columns, 1 mb_rows
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [6:0]           cfg_data
);

	bsvlc_pkg::dp_cmd_t    cmd;
	bsvlc_pkg::dp_status_t stat;

	// registers are always writable; writes must come only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	// sequencer: accept a word, step decodes, hand off last result
	bsvlc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// bit buffer, header tracking, vlc table, pending and output registers
	bsvlc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	// a commit never overwrites a result the output side still holds
	`BSVLC_ASSERT_IMP(a_commit_room, clk, arst_n, cmd.commit, !stat.pend_valid || stat.out_free)
	// a new transaction starts with nothing pending
	`BSVLC_ASSERT_IMP(a_accept_clean, clk, arst_n, cmd.accept, !stat.pend_valid)
	// the closing hand-off always marks the last result of the word
	`BSVLC_ASSERT_NXT(a_finish_last, clk, arst_n, cmd.finish, out_valid && out_item.last_of_input)

endmodule

@@ tb/bs_vlc_run_level_decoder_top_test.sv @@
// self-checking testbench for the run/level vlc decoder top level
`timescale 1ns / 1ps

module bs_vlc_run_level_decoder_top_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_WORDS = 128;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	bsvlc_pkg::in_item_t in_item;
	logic out_valid;
	logic out_stall = 1'b0;
	bsvlc_pkg::out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [6:0] cfg_data;

	bs_vlc_run_level_decoder_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// decoder model state: bit buffer is left aligned in 64 bits
	// ---------------------------------------------------------------
	logic [63:0] bit_buf;
	int unsigned bit_cnt;
	int unsigned hdr_idx;
	int unsigned qscale;
	int unsigned blk_cnt;
	bit want_dc;
	bit frame_over;
	bit flushing;
	int unsigned n_cols;
	int unsigned n_rows;

	bsvlc_pkg::out_item_t word_codes[$];     // codes caused by the word being predicted
	bsvlc_pkg::out_item_t expected_codes[$]; // codes still owed by the block
	int errors = 0;
	int dir_errors;
	int codes_seen = 0;
	int words_sent;
	longint cycles = 0;

	function automatic int unsigned peek(int k);
		return int'((bit_buf >> (64 - k)) & ((64'd1 << k) - 1));
	endfunction

	function void drop(int k);
		bit_buf = bit_buf << k;
		bit_cnt = (bit_cnt > k) ? bit_cnt - k : 0;
	endfunction

	function void clear_frame();
		bit_buf = '0;
		bit_cnt = 0;
		hdr_idx = 0;
		qscale = 1;
		blk_cnt = 0;
		want_dc = 1'b1;
		frame_over = 1'b0;
		flushing = 1'b0;
	endfunction

	function void add_code(logic [15:0] code, logic [1:0] st);
		bsvlc_pkg::out_item_t r;
		r.code_word = code;
		r.status = st;
		r.last_of_input = 1'b0;
		word_codes.push_back(r);
	endfunction

	// one code per pass, until the buffer runs short, the frame ends or MAX_RESULTS codes are made
	function void decode_codes();
		int unsigned nblocks;
		int unsigned win;
		int hit;
		bit is_eob;
		logic [9:0] lv;
		nblocks = n_cols * n_rows * 6;
		while (word_codes.size() < bsvlc_pkg::MAX_RESULTS) begin
			if (blk_cnt >= nblocks) begin
				add_code('0, bsvlc_pkg::STAT_DONE);
				frame_over = 1'b1;
				return;
			end
			if (want_dc) begin
				if (flushing) begin
					if (bit_cnt == 0) begin
						add_code('0, bsvlc_pkg::STAT_DONE);
						frame_over = 1'b1;
						return;
					end
				end else if (bit_cnt < 10) begin
					return;
				end
				add_code(16'((qscale & 6'h3F) << 10) | 16'(peek(10)), bsvlc_pkg::STAT_CODE);
				drop(10);
				want_dc = 1'b0;
				continue;
			end
			is_eob = (bit_cnt >= 2 || flushing) && peek(2) == 2;
			if (!is_eob && !flushing) begin
				if (bit_cnt < 17) return;
				if (peek(6) == 1 && bit_cnt < 22) return;
			end
			if (is_eob) begin
				drop(2);
				add_code(bsvlc_pkg::EOB_WORD, bsvlc_pkg::STAT_CODE);
				want_dc = 1'b1;
				blk_cnt++;
				continue;
			end
			// escape: the 16 bits after the prefix are the code word itself
			if (peek(6) == 1) begin
				add_code(16'(peek(22)), bsvlc_pkg::STAT_CODE);
				drop(22);
				continue;
			end
			win = peek(16);
			hit = -1;
			for (int i = 0; i < bsvlc_pkg::VLC_N; i++) begin
				if (hit < 0 && (win >> (16 - bsvlc_pkg::VLC_TABLE[i].len))
						== bsvlc_pkg::VLC_TABLE[i].code)
					hit = i;
			end
			if (hit < 0) begin
				add_code('0, bsvlc_pkg::STAT_ERR);
				frame_over = 1'b1;
				return;
			end
			drop(bsvlc_pkg::VLC_TABLE[hit].len);
			lv = 10'(bsvlc_pkg::VLC_TABLE[hit].lev);
			if (peek(1) != 0) lv = -lv;
			drop(1);
			add_code({1'b0, bsvlc_pkg::VLC_TABLE[hit].run, lv}, bsvlc_pkg::STAT_CODE);
		end
	endfunction

	// works out the codes one input word causes; returns 0 if the word is ignored
	function bit predict_word(bsvlc_pkg::in_item_t it);
		bit run_dec;
		word_codes.delete();
		if (it.frame_start) clear_frame();
		if (frame_over) return 1'b0;
		run_dec = 1'b1;
		if (!flushing) begin
			if (hdr_idx < 4) begin
				if (hdr_idx == 2) qscale = (it.data_word[5:0] == 0) ? 1 : it.data_word[5:0];
				hdr_idx++;
				if (hdr_idx < 4) begin
					run_dec = 1'b0;
					if (it.frame_end) begin
						add_code('0, bsvlc_pkg::STAT_ERR);
						frame_over = 1'b1;
					end
				end
			end else if (bit_cnt <= 32) begin
				bit_buf |= 64'(it.data_word) << (48 - bit_cnt);
				bit_cnt += 16;
			end
			if (run_dec && it.frame_end) flushing = 1'b1;
		end
		if (run_dec) decode_codes();
		if (word_codes.size() > 0) word_codes[word_codes.size() - 1].last_of_input = 1'b1;
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// sender: bursts of random length with random gaps in between
	// ---------------------------------------------------------------
	int burst_left;

	task automatic send_word(bsvlc_pkg::in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item <= it;
		// sampled in the active region of the edge, so old values of the block
		do @(posedge clk); while (in_stall);
		foreach (word_codes[i]) expected_codes.push_back(word_codes[i]);
		words_sent++;
	endtask

	task automatic idle_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every owed code, then let a word with no code finish
	task automatic drain();
		idle_input();
		while (expected_codes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [6:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == bsvlc_pkg::CFG_MB_COLUMNS) n_cols = val;
		else n_rows = val;
	endtask

	// ---------------------------------------------------------------
	// receiver: stall mode (none, light, heavy, toggling) is chosen by bits of the count of cycles
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		case ((cycles >> 6) % 4)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			2: out_stall <= ($urandom_range(0, 9) < 7);
			default: out_stall <= cycles[2];
		endcase
	end

	// compare each result transaction with the oldest owed code
	always @(posedge clk) begin
		bsvlc_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			codes_seen++;
			if (expected_codes.size() == 0) begin
				errors++;
				$display("%0t: expected no code, actual code %h status %0d", $time,
					out_item.code_word, out_item.status);
			end else begin
				want = expected_codes.pop_front();
				if (out_item.code_word !== want.code_word) begin
					errors++;
					$display("%0t: code_word expected %h actual %h", $time,
						want.code_word, out_item.code_word);
				end
				if (out_item.status !== want.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, out_item.status);
				end
				if (out_item.last_of_input !== want.last_of_input) begin
					errors++;
					$display("%0t: last_of_input expected %0b actual %0b", $time,
						want.last_of_input, out_item.last_of_input);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// directed table: typed answers only where obvious
	// n_exp: -1 checked by the model, 0 no code, 1 the one typed code
	// ---------------------------------------------------------------
	typedef struct {
		logic [15:0] data;
		logic fs;
		logic fe;
		int n_exp;
		logic [15:0] code;
		logic [1:0] st;
	} dir_row_t;

	localparam int DIR_N = 21;
	dir_row_t dir_rows [DIR_N] = '{
		// first word after reset, no frame start, is header word 0
		'{16'h0000, 1'b0, 1'b0, 0, 16'h0000, bsvlc_pkg::STAT_CODE},
		'{16'hFFFF, 1'b0, 1'b0, 0, 16'h0000, bsvlc_pkg::STAT_CODE},
		// quantizer of zero reads as one
		'{16'h0000, 1'b0, 1'b0, 0, 16'h0000, bsvlc_pkg::STAT_CODE},
		'{16'hABCD, 1'b0, 1'b0, 0, 16'h0000, bsvlc_pkg::STAT_CODE},
		// all-ones dc, then too few bits for an ac code
		'{16'hFFC0, 1'b0, 1'b0, 1, 16'h07FF, bsvlc_pkg::STAT_CODE},
		'{16'h5A5A, 1'b0, 1'b0, -1, 16'h0000, bsvlc_pkg::STAT_CODE},
		'{16'hC9B1, 1'b0, 1'b0, -1, 16'h0000, bsvlc_pkg::STAT_CODE},
		'{16'h0000, 1'b0, 1'b1, -1, 16'h0000, bsvlc_pkg::STAT_CODE},
		// frame end inside the header is an error
		'{16'h1234, 1'b1, 1'b0, 0, 16'h0000, bsvlc_pkg::STAT_CODE},
		'{16'h0000, 1'b0, 1'b1, 1, 16'h0000, bsvlc_pkg::STAT_ERR},
		// ended frame ignores words until the next frame start
		'{16'hFFFF, 1'b0, 1'b0, 0, 16'h0000, bsvlc_pkg::STAT_CODE},
		// quantizer 63, zero dc, then an all-zero window is a bad code
		'{16'h0000, 1'b1, 1'b0, 0, 16'h0000, bsvlc_pkg::STAT_CODE},
		'{16'h0000, 1'b0, 1'b0, 0, 16'h0000, bsvlc_pkg::STAT_CODE},
		'{16'hFFBF, 1'b0, 1'b0, 0, 16'h0000, bsvlc_pkg::STAT_CODE},
		'{16'h0000, 1'b0, 1'b0, 0, 16'h0000, bsvlc_pkg::STAT_CODE},
		'{16'h0000, 1'b0, 1'b0, 1, 16'hFC00, bsvlc_pkg::STAT_CODE},
		'{16'h0000, 1'b0, 1'b1, 1, 16'h0000, bsvlc_pkg::STAT_ERR},
		// frame end on the last header word: no bits left, frame finished
		'{16'h0001, 1'b1, 1'b0, 0, 16'h0000, bsvlc_pkg::STAT_CODE},
		'{16'h0000, 1'b0, 1'b0, 0, 16'h0000, bsvlc_pkg::STAT_CODE},
		'{16'h0000, 1'b0, 1'b0, 0, 16'h0000, bsvlc_pkg::STAT_CODE},
		'{16'hFFFF, 1'b0, 1'b1, 1, 16'h0000, bsvlc_pkg::STAT_DONE}
	};

	// ---------------------------------------------------------------
	// random frames built from real codes
	// ---------------------------------------------------------------
	bit frame_bits[$];
	bsvlc_pkg::in_item_t frame_words[$];

	function void push_bits(int unsigned v, int n);
		for (int i = n - 1; i >= 0; i--) frame_bits.push_back(v[i]);
	endfunction

	function void build_frame(int n_blk);
		int unsigned pick;
		int n_ac;
		bsvlc_pkg::in_item_t it;
		frame_bits.delete();
		frame_words.delete();
		for (int b = 0; b < n_blk; b++) begin
			push_bits($urandom_range(0, 1023), 10);
			n_ac = $urandom_range(0, 6);
			for (int a = 0; a < n_ac; a++) begin
				if ($urandom_range(0, 9) == 0) begin
					push_bits(1, 6);
					push_bits($urandom_range(0, 65535), 16);
				end else begin
					pick = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 14)
						: $urandom_range(0, bsvlc_pkg::VLC_N - 1);
					push_bits(bsvlc_pkg::VLC_TABLE[pick].code, bsvlc_pkg::VLC_TABLE[pick].len);
					push_bits($urandom_range(0, 1), 1);
				end
			end
			push_bits(2, 2);
		end
		// padding after the last block is mostly zero
		while (frame_bits.size() % 16 != 0)
			frame_bits.push_back(($urandom_range(0, 7) == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
		for (int h = 0; h < 4; h++) begin
			it.data_word = 16'($urandom_range(0, 65535));
			it.frame_start = (h == 0);
			it.frame_end = 1'b0;
			frame_words.push_back(it);
		end
		for (int w = 0; w < frame_bits.size() / 16; w++) begin
			for (int k = 0; k < 16; k++) it.data_word[15 - k] = frame_bits[w * 16 + k];
			it.frame_start = 1'b0;
			it.frame_end = 1'b0;
			frame_words.push_back(it);
		end
		frame_words[frame_words.size() - 1].frame_end = 1'b1;
	endfunction

	// mostly well formed; some noise and some broken frames
	function void make_frame();
		int kind;
		bsvlc_pkg::in_item_t it;
		kind = $urandom_range(0, 19);
		build_frame($urandom_range(1, 8));
		if (kind == 0) begin
			// pure noise words
			foreach (frame_words[i]) begin
				frame_words[i].data_word = 16'($urandom_range(0, 65535));
				frame_words[i].frame_end = ($urandom_range(0, 7) == 0);
			end
		end else if (kind == 1) begin
			// cut short: frame end lands early, maybe in the header
			it = frame_words[$urandom_range(1, frame_words.size() - 1)];
			while (frame_words.size() > 1 && frame_words[frame_words.size() - 1] != it)
				void'(frame_words.pop_back());
			frame_words[frame_words.size() - 1].frame_end = 1'b1;
		end else if (kind == 2) begin
			// no frame end: next frame start cuts it off
			frame_words[frame_words.size() - 1].frame_end = 1'b0;
		end else if (kind == 3) begin
			// words after the frame end, which are ignored
			for (int i = 0; i < 2; i++) begin
				it.data_word = 16'($urandom_range(0, 65535));
				it.frame_start = 1'b0;
				it.frame_end = 1'($urandom_range(0, 1));
				frame_words.push_back(it);
			end
		end
	endfunction

	typedef struct {
		logic [6:0] cols;
		logic [5:0] rows;
	} frame_size_t;

	localparam int PHASES = 4;
	frame_size_t phase_size [PHASES] = '{'{7'd1, 6'd1}, '{7'd64, 6'd32}, '{7'd2, 6'd3},
		'{7'd1, 6'd32}};

	initial begin
		bsvlc_pkg::in_item_t it;
		int counted;
		bit paused;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = bsvlc_pkg::CFG_MB_COLUMNS;
		cfg_data = '0;
		dir_errors = 0;
		words_sent = 0;
		burst_left = 0;
		paused = 1'b0;
		n_cols = 20;
		n_rows = 15;
		clear_frame();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset frame size
		foreach (dir_rows[r]) begin
			it.data_word = dir_rows[r].data;
			it.frame_start = dir_rows[r].fs;
			it.frame_end = dir_rows[r].fe;
			void'(predict_word(it));
			if (dir_rows[r].n_exp == 0 && word_codes.size() != 0) begin
				dir_errors++;
				$display("%0t: row %0d expected no code, model gives %0d", $time, r,
					word_codes.size());
			end else if (dir_rows[r].n_exp == 1) begin
				word_codes.delete();
				add_code(dir_rows[r].code, dir_rows[r].st);
				word_codes[0].last_of_input = 1'b1;
			end
			send_word(it);
		end
		drain();

		// random part: each phase a new frame size, written only while idle
		counted = 0;
		for (int p = 0; p < PHASES; p++) begin
			write_reg(bsvlc_pkg::CFG_MB_COLUMNS, phase_size[p].cols);
			write_reg(bsvlc_pkg::CFG_MB_ROWS, 7'(phase_size[p].rows));
			while (counted < (p + 1) * RANDOM_WORDS / PHASES) begin
				make_frame();
				foreach (frame_words[i]) begin
					if (predict_word(frame_words[i])) counted++;
					send_word(frame_words[i]);
					// hold off once mid frame until everything owed is back
					if (!paused && p == 1 && i == 5) begin
						paused = 1'b1;
						idle_input();
						while (expected_codes.size() != 0) @(posedge clk);
					end
				end
			end
			drain();
		end

		$display("covered %0d input words and %0d result transactions", words_sent,
			codes_seen);
		$display("frame sizes from 1x1 up to 64x32 macroblocks, with noise and cut frames");
		if (errors == 0 && dir_errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bsvlc_pkg.sv
rtl/bsvlc_ctrl.sv
rtl/bsvlc_datapath.sv
rtl/bs_vlc_run_level_decoder_top.sv
tb/bs_vlc_run_level_decoder_top_test.sv
